### rtl/fdnr_pkg.sv
`timescale 1ns / 1ps
package fdnr_pkg;

    localparam int LINE_COUNT          = 8;
    localparam int SAMPLE_RATE_DEF     = 48000;
    localparam int PREDELAY_FRAMES_DEF = 9601;
    localparam int TAP_WEIGHT          = 26214;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_DECAY_LO  = 3'd0;
    localparam logic [2:0] REG_DECAY_HI  = 3'd1;
    localparam logic [2:0] REG_DAMP_LO   = 3'd2;
    localparam logic [2:0] REG_DAMP_HI   = 3'd3;
    localparam logic [2:0] REG_SMOOTH    = 3'd4;
    localparam logic [2:0] REG_LEFT_GAIN = 3'd5;
    localparam logic [2:0] REG_RIGHT_GAIN = 3'd6;
    localparam logic [2:0] REG_PREDELAY  = 3'd7;

    typedef struct packed {
        logic signed [23:0] dry_sample;
        logic               last_of_block;
    } fdnr_in_t;

    typedef struct packed {
        logic signed [23:0] wet_left;
        logic signed [23:0] wet_right;
        logic [24:0]        tail_magnitude;
        logic               block_done;
    } fdnr_out_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LN_RD,
        ST_LN_MUL,
        ST_LN_WB,
        ST_FB_MUL,
        ST_FB_WB,
        ST_TL_MUL,
        ST_TL_WB,
        ST_TR_MUL,
        ST_TR_WB,
        ST_SL_MUL,
        ST_SL_WB,
        ST_SR_MUL,
        ST_SR_WB,
        ST_PD_WR,
        ST_PD_RD,
        ST_OL_MUL,
        ST_OL_WB,
        ST_OR_MUL,
        ST_OR_WB
    } fdnr_state_t;

    // Line lengths in tenths of a millisecond
    function automatic int line_tenths(input int i);
        int t;
        case (i)
            0:       t = 191;
            1:       t = 237;
            2:       t = 293;
            3:       t = 371;
            4:       t = 413;
            5:       t = 479;
            6:       t = 533;
            default: t = 597;
        endcase
        return t;
    endfunction

    function automatic int line_len(input int i, input int sr);
        int l;
        l = line_tenths(i) * sr / 10000;
        return (l > 0) ? l : 1;
    endfunction

    function automatic int line_base(input int i, input int sr);
        int b;
        b = 0;
        for (int k = 0; k < i; k++)
            b = b + line_len(k, sr);
        return b;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [45:0] v);
        logic signed [23:0] r;
        if (v > 46'sd8388607)
            r = 24'sh7fffff;
        else if (v < -46'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

    // Round half up, then floor
    function automatic logic signed [45:0] rnd_shift(input logic signed [44:0] p,
                                                     input int sh);
        logic signed [45:0] t;
        t = 46'(p) + (46'sd1 <<< (sh - 1));
        return t >>> sh;
    endfunction

endpackage

### rtl/fdnr_ram.sv
`timescale 1ns / 1ps
module fdnr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### rtl/fdn_reverb_sample_step_unit.sv
`timescale 1ns / 1ps
// A new sample is taken only when idle, after the last result is loaded, which waits while
// the result slot is still full. Eight lines pass one shared 28x17 multiplier in two rounds
// (read, multiply, write-back; then multiply, write-back), then taps, smoother and output
// gains take it in turn. Reset: control and filter state clear at once, then a clearing pass
// over max(line store depth, PREDELAY_FRAMES) entries (14943 at 48 kHz) zeroes both memories.
module fdn_reverb_sample_step_unit #(
    parameter int SAMPLE_RATE     = fdnr_pkg::SAMPLE_RATE_DEF,
    parameter int PREDELAY_FRAMES = fdnr_pkg::PREDELAY_FRAMES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fdnr_pkg::fdnr_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fdnr_pkg::fdnr_out_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    import fdnr_pkg::*;

    localparam int DEPTH     = line_base(LINE_COUNT, SAMPLE_RATE);
    localparam int AW        = $clog2(DEPTH);
    localparam int LPW       = $clog2(line_len(LINE_COUNT - 1, SAMPLE_RATE));
    localparam int PW        = $clog2(PREDELAY_FRAMES);
    localparam int PDW       = (PW > 14) ? PW : 14;
    localparam int CLR_DEPTH = (DEPTH > PREDELAY_FRAMES) ? DEPTH : PREDELAY_FRAMES;
    localparam int CW        = $clog2(CLR_DEPTH);

    fdnr_state_t st_reg, st_next;

    logic [63:0] decay_lo_reg, decay_hi_reg, damp_lo_reg, damp_hi_reg;
    logic [15:0] smooth_reg, lgain_reg, rgain_reg;
    logic [13:0] pdsamp_reg;

    logic [2:0]          idx_reg;
    logic [CW-1:0]       clr_reg;
    logic signed [23:0]  lp_reg [LINE_COUNT];
    logic [LPW-1:0]      ptr_reg [LINE_COUNT];
    logic signed [23:0]  sl_reg, sr_reg;
    logic [PW-1:0]       pwp_reg, rd_reg;
    logic signed [23:0]  x_reg, v_reg, ol_reg;
    logic                last_reg;
    logic signed [26:0]  sum_reg, tapl_reg, tapr_reg, tl_reg, tr_reg;
    logic signed [44:0]  prod_reg;
    logic [24:0]         mag_reg;
    fdnr_out_t           out_reg;
    logic                out_valid_reg;

    logic [AW-1:0]       base_tbl [LINE_COUNT];
    logic [LPW-1:0]      last_tbl [LINE_COUNT];

    genvar g;
    generate
        for (g = 0; g < LINE_COUNT; g++)
        begin : g_tbl
            assign base_tbl[g] = AW'(line_base(g, SAMPLE_RATE));
            assign last_tbl[g] = LPW'(line_len(g, SAMPLE_RATE) - 1);
        end
    endgenerate

    // Configuration port
    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[5:3];

    always_comb
    begin
        unique case (cfg_idx)
            REG_DECAY_LO:   prdata = decay_lo_reg;
            REG_DECAY_HI:   prdata = decay_hi_reg;
            REG_DAMP_LO:    prdata = damp_lo_reg;
            REG_DAMP_HI:    prdata = damp_hi_reg;
            REG_SMOOTH:     prdata = {48'd0, smooth_reg};
            REG_LEFT_GAIN:  prdata = {48'd0, lgain_reg};
            REG_RIGHT_GAIN: prdata = {48'd0, rgain_reg};
            REG_PREDELAY:   prdata = {50'd0, pdsamp_reg};
            default:        prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_lo_reg <= '0;
            decay_hi_reg <= '0;
            damp_lo_reg  <= '0;
            damp_hi_reg  <= '0;
            smooth_reg   <= '0;
            lgain_reg    <= '0;
            rgain_reg    <= '0;
            pdsamp_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_DECAY_LO:   decay_lo_reg <= pwdata;
                REG_DECAY_HI:   decay_hi_reg <= pwdata;
                REG_DAMP_LO:    damp_lo_reg  <= pwdata;
                REG_DAMP_HI:    damp_hi_reg  <= pwdata;
                REG_SMOOTH:     smooth_reg   <= pwdata[15:0];
                REG_LEFT_GAIN:  lgain_reg    <= pwdata[15:0];
                REG_RIGHT_GAIN: rgain_reg    <= pwdata[15:0];
                REG_PREDELAY:   pdsamp_reg   <= pwdata[13:0];
                default:        ;
            endcase
        end
    end

    // Per-line coefficients
    logic [127:0] decay_all, damp_all;
    logic [15:0]  decay_c, damp_c;
    assign decay_all = {decay_hi_reg, decay_lo_reg};
    assign damp_all  = {damp_hi_reg, damp_lo_reg};
    assign decay_c   = decay_all[{idx_reg, 4'b0000} +: 16];
    assign damp_c    = damp_all[{idx_reg, 4'b0000} +: 16];

    // Memories
    logic [AW-1:0]  ln_addr;
    logic           dly_we;
    logic [AW-1:0]  dly_waddr;
    logic [23:0]    dly_wdata, dly_rdata;
    logic           ring_we;
    logic [PW-1:0]  ring_waddr;
    logic [47:0]    ring_wdata, ring_rdata;

    assign ln_addr = base_tbl[idx_reg] + AW'(ptr_reg[idx_reg]);

    fdnr_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_dly_ram (
        .clk   (clk),
        .we    (dly_we),
        .waddr (dly_waddr),
        .wdata (dly_wdata),
        .raddr (ln_addr),
        .rdata (dly_rdata)
    );

    fdnr_ram #(.WIDTH(48), .DEPTH(PREDELAY_FRAMES)) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (rd_reg),
        .rdata (ring_rdata)
    );

    // Shared multiplier operands
    logic signed [27:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [44:0] mul_p;
    logic signed [23:0] tl_sat, tr_sat;
    assign tl_sat = sat24(46'(tl_reg));
    assign tr_sat = sat24(46'(tr_reg));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (st_reg)
            ST_LN_MUL:
            begin
                mul_a = 28'(lp_reg[idx_reg]) - 28'($signed(dly_rdata));
                mul_b = $signed({1'b0, damp_c});
            end
            ST_FB_MUL:
            begin
                mul_a = (28'(lp_reg[idx_reg]) <<< 2) - 28'(sum_reg);
                mul_b = $signed({1'b0, decay_c});
            end
            ST_TL_MUL:
            begin
                mul_a = 28'(tapl_reg);
                mul_b = 17'(TAP_WEIGHT);
            end
            ST_TR_MUL:
            begin
                mul_a = 28'(tapr_reg);
                mul_b = 17'(TAP_WEIGHT);
            end
            ST_SL_MUL:
            begin
                mul_a = 28'(sl_reg) - 28'(tl_sat);
                mul_b = $signed({1'b0, smooth_reg});
            end
            ST_SR_MUL:
            begin
                mul_a = 28'(sr_reg) - 28'(tr_sat);
                mul_b = $signed({1'b0, smooth_reg});
            end
            ST_OL_MUL:
            begin
                mul_a = 28'($signed(ring_rdata[47:24]));
                mul_b = $signed({1'b0, lgain_reg});
            end
            ST_OR_MUL:
            begin
                mul_a = 28'($signed(ring_rdata[23:0]));
                mul_b = $signed({1'b0, rgain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 45'(mul_a) * 45'(mul_b);

    logic signed [45:0] r16, r18, r12;
    assign r16 = rnd_shift(prod_reg, 16);
    assign r18 = rnd_shift(prod_reg, 18);
    assign r12 = rnd_shift(prod_reg, 12);

    logic signed [23:0] y_new;
    assign y_new = sat24(46'(v_reg) + r16);

    // Pre-delay read address
    logic [PDW-1:0] pd_ext, pd_lim;
    logic [PW-1:0]  pd;
    logic [PW:0]    rd_wrap;
    logic [PW-1:0]  rd_next;
    assign pd_ext  = PDW'(pdsamp_reg);
    assign pd_lim  = (pd_ext > PDW'(PREDELAY_FRAMES - 1)) ? PDW'(PREDELAY_FRAMES - 1) : pd_ext;
    assign pd      = PW'(pd_lim);
    assign rd_wrap = (PW + 1)'(pwp_reg) + (PW + 1)'(PREDELAY_FRAMES) - (PW + 1)'(pd);
    assign rd_next = (pwp_reg >= pd) ? (pwp_reg - pd) : rd_wrap[PW-1:0];

    // Tail magnitude
    logic [26:0] abs_l, abs_r;
    logic [27:0] mag_sum;
    assign abs_l   = tl_reg[26] ? 27'(-tl_reg) : 27'(tl_reg);
    assign abs_r   = tr_reg[26] ? 27'(-tr_reg) : 27'(tr_reg);
    assign mag_sum = 28'(abs_l) + 28'(abs_r);

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_CLEAR:  st_next = (clr_reg == CW'(CLR_DEPTH - 1)) ? ST_IDLE : ST_CLEAR;
            ST_IDLE:   st_next = in_valid ? ST_LN_RD : ST_IDLE;
            ST_LN_RD:  st_next = ST_LN_MUL;
            ST_LN_MUL: st_next = ST_LN_WB;
            ST_LN_WB:  st_next = (idx_reg == 3'd7) ? ST_FB_MUL : ST_LN_RD;
            ST_FB_MUL: st_next = ST_FB_WB;
            ST_FB_WB:  st_next = (idx_reg == 3'd7) ? ST_TL_MUL : ST_FB_MUL;
            ST_TL_MUL: st_next = ST_TL_WB;
            ST_TL_WB:  st_next = ST_TR_MUL;
            ST_TR_MUL: st_next = ST_TR_WB;
            ST_TR_WB:  st_next = ST_SL_MUL;
            ST_SL_MUL: st_next = ST_SL_WB;
            ST_SL_WB:  st_next = ST_SR_MUL;
            ST_SR_MUL: st_next = ST_SR_WB;
            ST_SR_WB:  st_next = ST_PD_WR;
            ST_PD_WR:  st_next = ST_PD_RD;
            ST_PD_RD:  st_next = ST_OL_MUL;
            ST_OL_MUL: st_next = ST_OL_WB;
            ST_OL_WB:  st_next = ST_OR_MUL;
            ST_OR_MUL: st_next = ST_OR_WB;
            ST_OR_WB:  st_next = out_free ? ST_IDLE : ST_OR_WB;
            default:   st_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_ready   = (st_reg == ST_IDLE);
        dly_we     = 1'b0;
        dly_waddr  = ln_addr;
        dly_wdata  = sat24(46'(x_reg) + r18);
        ring_we    = 1'b0;
        ring_waddr = pwp_reg;
        ring_wdata = {sl_reg, sr_reg};
        if (st_reg == ST_CLEAR)
        begin
            dly_we     = (32'(clr_reg) < DEPTH);
            dly_waddr  = clr_reg[AW-1:0];
            dly_wdata  = '0;
            ring_we    = (32'(clr_reg) < PREDELAY_FRAMES);
            ring_waddr = clr_reg[PW-1:0];
            ring_wdata = '0;
        end
        else if (st_reg == ST_FB_WB)
            dly_we = 1'b1;
        else if (st_reg == ST_PD_WR)
            ring_we = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_CLEAR;
        else
            st_reg <= st_next;
    end

    // Persistent state and sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            clr_reg       <= '0;
            sl_reg        <= '0;
            sr_reg        <= '0;
            pwp_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < LINE_COUNT; k++)
            begin
                lp_reg[k]  <= '0;
                ptr_reg[k] <= '0;
            end
        end
        else
        begin
            if (st_reg == ST_CLEAR)
                clr_reg <= clr_reg + CW'(1);
            if (st_reg == ST_IDLE)
                idx_reg <= '0;
            if (st_reg == ST_LN_WB)
            begin
                lp_reg[idx_reg] <= y_new;
                idx_reg         <= idx_reg + 3'd1;
            end
            if (st_reg == ST_FB_WB)
            begin
                ptr_reg[idx_reg] <= (ptr_reg[idx_reg] == last_tbl[idx_reg])
                                    ? '0 : ptr_reg[idx_reg] + LPW'(1);
                idx_reg          <= idx_reg + 3'd1;
            end
            if (st_reg == ST_SL_WB)
                sl_reg <= sat24(46'(tl_sat) + r16);
            if (st_reg == ST_SR_WB)
                sr_reg <= sat24(46'(tr_sat) + r16);
            if (st_reg == ST_PD_WR)
                pwp_reg <= (32'(pwp_reg) == PREDELAY_FRAMES - 1) ? '0 : pwp_reg + PW'(1);
            // Load the result slot, drop it once taken
            if (st_reg == ST_OR_WB && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers of one transaction
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && in_valid)
        begin
            x_reg    <= in_data.dry_sample;
            last_reg <= in_data.last_of_block;
            sum_reg  <= '0;
            tapl_reg <= '0;
            tapr_reg <= '0;
        end
        if (st_reg == ST_LN_MUL)
            v_reg <= $signed(dly_rdata);
        if (st_reg == ST_LN_MUL || st_reg == ST_FB_MUL || st_reg == ST_TL_MUL ||
            st_reg == ST_TR_MUL || st_reg == ST_SL_MUL || st_reg == ST_SR_MUL ||
            st_reg == ST_OL_MUL || st_reg == ST_OR_MUL)
            prod_reg <= mul_p;
        if (st_reg == ST_LN_WB)
        begin
            sum_reg  <= sum_reg + 27'(y_new);
            tapl_reg <= idx_reg[0] ? tapl_reg - 27'(y_new) : tapl_reg + 27'(y_new);
            tapr_reg <= idx_reg[1] ? tapr_reg - 27'(y_new) : tapr_reg + 27'(y_new);
        end
        if (st_reg == ST_TL_WB)
            tl_reg <= r16[26:0];
        if (st_reg == ST_TR_WB)
            tr_reg <= r16[26:0];
        if (st_reg == ST_SL_MUL)
            mag_reg <= (mag_sum > 28'd33554431) ? 25'h1ffffff : mag_sum[24:0];
        if (st_reg == ST_PD_WR)
            rd_reg <= rd_next;
        if (st_reg == ST_OL_WB)
            ol_reg <= sat24(r12);
        if (st_reg == ST_OR_WB && out_free)
        begin
            out_reg.wet_left       <= ol_reg;
            out_reg.wet_right      <= sat24(r12);
            out_reg.tail_magnitude <= mag_reg;
            out_reg.block_done     <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_CLEAR) |-> !in_ready)
        else $error("input taken during clearing pass");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_FB_WB) |-> (ptr_reg[idx_reg] <= last_tbl[idx_reg]))
        else $error("line pointer beyond line length");

    a_pwp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (PW + 1)'(pwp_reg) < (PW + 1)'(PREDELAY_FRAMES))
        else $error("pre-delay pointer beyond ring");

    a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (st_reg == ST_LN_RD && idx_reg == 3'd0))
        else $error("sequence did not start at line zero");

    a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_OR_WB && out_valid_reg && !out_ready) |=> $stable(out_reg))
        else $error("pending result overwritten");
endmodule
